// ----- hdl/mcsb_pkg.sv -----
// mcsb_pkg: shared widths, register codes, reset values and the command type
// for the mean_center_scale_bias block. No dependencies.
package mcsb_pkg;

  localparam int unsigned VECTOR_MAX_DEF = 64;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned SUM_W = 22;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned MEAN_W = DATA_W + 1;
  localparam int unsigned DIFF_W = DATA_W + 2;
  localparam int unsigned PROD_W = DIFF_W + DATA_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0] VECTOR_LENGTH_RST = 7'd64;
  localparam logic [DATA_W-1:0] SCALE_FACTOR_RST = 16'd256;
  localparam logic [DATA_W-1:0] BIAS_OFFSET_RST = 16'd0;
  localparam logic [DATA_W-1:0] RESULT_MAX = 16'h7fff;
  localparam logic [DATA_W-1:0] RESULT_MIN = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_LENGTH = 2'd0,
    REG_SCALE_FACTOR  = 2'd1,
    REG_BIAS_OFFSET   = 2'd2
  } cfg_reg_t;

  // One finished vector handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [LEN_W-1:0]        count;
    logic                    bank;
  } cmd_t;

  function automatic int unsigned idx_bits(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- hdl/mcsb_if.sv -----
// mcsb_sample_if / mcsb_result_if: valid-ready channels of the block.
// Depends on mcsb_pkg for the payload widths.
interface mcsb_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mcsb_pkg::DATA_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mcsb_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mcsb_pkg::DATA_W-1:0]    result_value;
  logic                                  last_of_vector;

  modport source (output valid, output result_value, output last_of_vector, input ready);
  modport sink   (input valid, input result_value, input last_of_vector, output ready);
endinterface

// ----- hdl/mean_center_scale_bias.sv -----
// mean_center_scale_bias: top level. Holds the configuration registers and
// connects front, command queue, back and the double-banked sample RAM.
// Uses mcsb_pkg, mcsb_sample_if, mcsb_result_if, mcsb_front, mcsb_queue,
// mcsb_back, mcsb_ram.
//
// Usage:
//   samples: one signed Q8.8 item per handshake (valid & ready). Each vector
//   has vector_length items (0 acts as 1, above VECTOR_MAX as VECTOR_MAX).
//   results: one item per stored sample, (sample - mean) * scale >> 8 + bias,
//   saturated, in input order; last_of_vector marks the vector's final item.
//   cfg: cfg_we writes cfg_data to register cfg_index, no read-back.
// Timing:
//   The front takes one sample per cycle while a bank is free. After the
//   last sample of a vector, the back (once idle) computes the mean (one
//   quotient bit per cycle), then issues one read per cycle while the output
//   pipeline advances; results then leave at one result per cycle unless
//   results.ready stalls them. The sample RAM has two banks, so the next
//   vector loads while the back works.
// Reset: clears counters, queue, pipeline and restores register defaults;
//   there is no clearing pass. When results stall, the output pipeline holds;
//   samples keep being taken until both banks hold finished vectors.
module mean_center_scale_bias #(
  parameter int unsigned VECTOR_MAX = mcsb_pkg::VECTOR_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  mcsb_sample_if.sink                         samples,
  mcsb_result_if.source                       results,
  input  logic                                cfg_we,
  input  logic [mcsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcsb_pkg::DATA_W-1:0]         cfg_data
);
  import mcsb_pkg::*;

  localparam int unsigned IDX_W     = idx_bits(VECTOR_MAX);
  localparam int unsigned RAM_DEPTH = 2 ** (IDX_W + 1);

  logic [LEN_W-1:0]         vector_length;
  logic signed [DATA_W-1:0] scale_factor;
  logic signed [DATA_W-1:0] bias_offset;

  logic             q_push;
  cmd_t             q_cmd;
  logic             q_pop;
  cmd_t             q_head;
  logic             q_valid;
  logic             q_full;
  logic             ram_we;
  logic [IDX_W:0]   ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W:0]   ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VECTOR_LENGTH_RST;
      scale_factor  <= SCALE_FACTOR_RST;
      bias_offset   <= BIAS_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VECTOR_LENGTH: vector_length <= cfg_data[LEN_W-1:0];
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data;
        REG_BIAS_OFFSET:   bias_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  mcsb_front #(.VECTOR_MAX(VECTOR_MAX)) u_front (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples),
    .vector_length (vector_length),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  mcsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  mcsb_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcsb_back #(.VECTOR_MAX(VECTOR_MAX)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .scale_factor (scale_factor),
    .bias_offset  (bias_offset),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .results      (results)
  );

  a_no_load_when_banks_busy: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !samples.ready)
    else $error("sample taken while both banks hold queued vectors");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back released a bank with an empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_valid)
    else $error("queued vector command lost");

endmodule

// ----- hdl/mcsb_ram.sv -----
// mcsb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcsb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/mcsb_queue.sv -----
// mcsb_queue: short command queue between front and back. The head stays
// until the back pops it, which also marks its sample bank free. Uses mcsb_pkg.
module mcsb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mcsb_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output mcsb_pkg::cmd_t  head,
  output logic            head_valid,
  output logic            full
);
  import mcsb_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head       = entries[rd_ptr];
  assign head_valid = fill != '0;
  assign full       = fill == CNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/mcsb_front.sv -----
// mcsb_front: accepts samples, writes them to the current bank and keeps the
// running sum; at vector end it queues a command. Uses mcsb_pkg, mcsb_sample_if.
module mcsb_front #(
  parameter int unsigned VECTOR_MAX = mcsb_pkg::VECTOR_MAX_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  mcsb_sample_if.sink                                samples,
  input  logic [mcsb_pkg::LEN_W-1:0]                 vector_length,
  input  logic                                       q_full,
  output logic                                       q_push,
  output mcsb_pkg::cmd_t                             q_cmd,
  output logic                                       ram_we,
  output logic [mcsb_pkg::idx_bits(VECTOR_MAX):0]    ram_waddr,
  output logic [mcsb_pkg::DATA_W-1:0]                ram_wdata
);
  import mcsb_pkg::*;

  localparam int unsigned IDX_W = idx_bits(VECTOR_MAX);

  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [LEN_W-1:0]        load_count;
  logic [LEN_W-1:0]        count_next;
  logic [LEN_W-1:0]        eff_len;
  logic                    wr_bank;
  logic                    accept;
  logic                    vec_end;

  always_comb begin
    if (vector_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(vector_length) > VECTOR_MAX) begin
      eff_len = LEN_W'(VECTOR_MAX);
    end else begin
      eff_len = vector_length;
    end
  end

  assign samples.ready = !q_full;
  assign accept        = samples.valid && samples.ready;
  assign sum_next      = running_sum + {{(SUM_W-DATA_W){samples.sample[DATA_W-1]}}, samples.sample};
  assign count_next    = load_count + LEN_W'(1);
  assign vec_end       = count_next >= eff_len;

  assign ram_we    = accept;
  assign ram_waddr = {wr_bank, load_count[IDX_W-1:0]};
  assign ram_wdata = samples.sample;

  assign q_push = accept && vec_end;
  assign q_cmd  = '{sum: sum_next, count: count_next, bank: wr_bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      load_count  <= '0;
      wr_bank     <= 1'b0;
    end else if (accept) begin
      if (vec_end) begin
        running_sum <= '0;
        load_count  <= '0;
        wr_bank     <= !wr_bank;
      end else begin
        running_sum <= sum_next;
        load_count  <= count_next;
      end
    end
  end

endmodule

// ----- hdl/mcsb_back.sv -----
// mcsb_back: per queued vector, divides the sum by the count one quotient bit
// a cycle, then streams the bank through subtract, multiply, shift, add and
// saturate. Uses mcsb_pkg, mcsb_result_if.
module mcsb_back #(
  parameter int unsigned VECTOR_MAX = mcsb_pkg::VECTOR_MAX_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_valid,
  input  mcsb_pkg::cmd_t                             q_head,
  output logic                                       q_pop,
  input  logic signed [mcsb_pkg::DATA_W-1:0]         scale_factor,
  input  logic signed [mcsb_pkg::DATA_W-1:0]         bias_offset,
  output logic                                       ram_re,
  output logic [mcsb_pkg::idx_bits(VECTOR_MAX):0]    ram_raddr,
  input  logic [mcsb_pkg::DATA_W-1:0]                ram_rdata,
  mcsb_result_if.source                              results
);
  import mcsb_pkg::*;

  localparam int unsigned IDX_W  = idx_bits(VECTOR_MAX);
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

  typedef enum logic [1:0] {IDLE, DIVIDE, EMIT} state_t;

  state_t                   state;
  logic [SUM_W-1:0]         dq;
  logic [LEN_W-1:0]         rem;
  logic                     neg;
  logic [STEP_W-1:0]        step;
  logic signed [MEAN_W-1:0] mean;
  logic [LEN_W-1:0]         rd_idx;

  logic                     s1_valid;
  logic                     s1_last;
  logic signed [MEAN_W-1:0] s1_mean;
  logic                     s2_valid;
  logic                     s2_last;
  logic signed [PROD_W-1:0] s2_prod;
  logic                     out_valid;
  logic [DATA_W-1:0]        out_value;
  logic                     out_last;

  logic                     adv;
  logic                     issue;
  logic                     issue_last;
  logic [SUM_W-1:0]         magnitude;
  logic [LEN_W:0]           rem_sh;
  logic                     q_bit;
  logic [LEN_W:0]           rem_sub;
  logic [LEN_W-1:0]         rem_next;
  logic [SUM_W-1:0]         dq_next;
  logic [MEAN_W-1:0]        quot;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-FRAC_W-1:0] shifted;
  logic signed [PROD_W-FRAC_W:0]   biased;
  logic [DATA_W-1:0]        sat_value;

  assign adv        = !out_valid || results.ready;
  assign issue      = (state == EMIT) && adv;
  assign issue_last = (rd_idx + LEN_W'(1)) == q_head.count;
  assign q_pop      = issue && issue_last;
  assign ram_re     = issue;
  assign ram_raddr  = {q_head.bank, rd_idx[IDX_W-1:0]};

  assign magnitude = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
  assign rem_sh    = {rem, dq[SUM_W-1]};
  assign q_bit     = rem_sh >= {1'b0, q_head.count};
  assign rem_sub   = rem_sh - {1'b0, q_head.count};
  assign rem_next  = q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
  assign dq_next   = {dq[SUM_W-2:0], q_bit};
  assign quot      = dq_next[MEAN_W-1:0];

  assign diff = {{2{ram_rdata[DATA_W-1]}}, ram_rdata} - {s1_mean[MEAN_W-1], s1_mean};

  // Arithmetic shift of the product floors; then bias and clamp to 16 bits.
  assign shifted = s2_prod[PROD_W-1:FRAC_W];
  assign biased  = {shifted[PROD_W-FRAC_W-1], shifted}
                 + {{(PROD_W-FRAC_W+1-DATA_W){bias_offset[DATA_W-1]}}, bias_offset};

  always_comb begin
    if (!biased[PROD_W-FRAC_W] && (|biased[PROD_W-FRAC_W-1:DATA_W-1])) begin
      sat_value = RESULT_MAX;
    end else if (biased[PROD_W-FRAC_W] && !(&biased[PROD_W-FRAC_W-1:DATA_W-1])) begin
      sat_value = RESULT_MIN;
    end else begin
      sat_value = biased[DATA_W-1:0];
    end
  end

  assign results.valid          = out_valid;
  assign results.result_value   = out_value;
  assign results.last_of_vector = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (q_valid) begin
            dq    <= magnitude;
            rem   <= '0;
            neg   <= q_head.sum[SUM_W-1];
            step  <= '0;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == DIV_LAST) begin
            mean   <= neg ? -$signed(quot) : $signed(quot);
            rd_idx <= '0;
            state  <= EMIT;
          end
        end
        EMIT: begin
          if (issue) begin
            rd_idx <= rd_idx + LEN_W'(1);
            if (issue_last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase

      if (adv) begin
        s1_valid  <= issue;
        s1_last   <= issue_last;
        s1_mean   <= mean;
        s2_valid  <= s1_valid;
        s2_last   <= s1_last;
        s2_prod   <= diff * scale_factor;
        out_valid <= s2_valid;
        out_value <= sat_value;
        out_last  <= s2_last;
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for mean_center_scale_bias. Drives sample items,
// writes the registers when idle and checks every result item against a local model.
// Depends on mcsb_pkg, mcsb_sample_if, mcsb_result_if and the RTL of the block.
module tb_top;
  import mcsb_pkg::*;

  localparam int ITEM_TARGET    = 410;
  localparam int SETTLE_CYCLES  = 32;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_LEN   = 400;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } norm_item_t;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  mcsb_sample_if sample_ch ();
  mcsb_result_if result_ch ();

  mean_center_scale_bias i_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the registers and the vector state
  logic [LEN_W-1:0]         len_reg   = VECTOR_LENGTH_RST;
  logic signed [DATA_W-1:0] scale_reg = SCALE_FACTOR_RST;
  logic signed [DATA_W-1:0] bias_reg  = BIAS_OFFSET_RST;
  logic signed [DATA_W-1:0] sample_mem [VECTOR_MAX_DEF];
  logic signed [SUM_W-1:0]  vec_sum   = '0;
  logic [LEN_W-1:0]         vec_count = '0;

  norm_item_t normalized_q[$];

  int error_count = 0;
  int sent_count = 0;
  int stall_cycles = 0;
  int hold_off_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_length(input logic [LEN_W-1:0] n);
    if (n == 0) return 1;
    if (n > VECTOR_MAX_DEF) return VECTOR_MAX_DEF;
    return n;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // Store and sum one sample; when the vector ends, queue all its normalized items.
  function automatic void center_scale_bias(input logic signed [DATA_W-1:0] s);
    int unsigned slot;
    longint mean;
    longint diff;
    longint prod;
    longint v;
    norm_item_t item;
    slot = (vec_count >= VECTOR_MAX_DEF) ? VECTOR_MAX_DEF - 1 : vec_count;
    sample_mem[slot] = s;
    vec_sum = vec_sum + SUM_W'(s);
    vec_count = LEN_W'(slot + 1);
    if (vec_count < eff_length(len_reg)) return;
    mean = longint'(vec_sum) / longint'(vec_count);
    for (int i = 0; i < vec_count; i++) begin
      diff = longint'(sample_mem[i]) - mean;
      prod = diff * longint'(scale_reg);
      v = (prod >>> FRAC_W) + longint'(bias_reg);
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      item.value = v[DATA_W-1:0];
      item.last = (i == vec_count - 1);
      normalized_q.push_back(item);
    end
    vec_sum = '0;
    vec_count = '0;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) center_scale_bias(sample_ch.sample);
      if (cfg_we) begin
        case (cfg_index)
          REG_VECTOR_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          REG_SCALE_FACTOR:  scale_reg = cfg_data;
          REG_BIAS_OFFSET:   bias_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    norm_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (normalized_q.size() == 0) begin
        note_error($sformatf("unexpected item: value %0d last %0b",
                             result_ch.result_value, result_ch.last_of_vector));
      end else begin
        want = normalized_q.pop_front();
        if (result_ch.result_value !== want.value || result_ch.last_of_vector !== want.last)
          note_error($sformatf("mismatch: expected value %0d last %0b, got value %0d last %0b",
                               want.value, want.last,
                               result_ch.result_value, result_ch.last_of_vector));
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result ready: long hold-off on request, else random stalls
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] s);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2: return DATA_W'($signed($urandom_range(0, 1023)) - 512);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_vector(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [LEN_W-1:0] n, input logic [DATA_W-1:0] sc,
                           input logic [DATA_W-1:0] bi);
    write_reg(REG_VECTOR_LENGTH, DATA_W'(n));
    write_reg(REG_SCALE_FACTOR, sc);
    write_reg(REG_BIAS_OFFSET, bi);
  endtask

  // wait for all queued items, then let the back end go quiet
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (normalized_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_vector(VECTOR_MAX_DEF - 2);
    settle();
  endtask

  task automatic test_saturation_extremes();
    write_all(7'd4, 16'h7fff, 16'h7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    settle();
    write_all(7'd4, 16'h8000, 16'h8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0001);
    send_sample(16'sh0000);
    settle();
  endtask

  task automatic test_short_lengths();
    write_all(7'd1, 16'h0100, 16'h1234);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    settle();
    write_reg(REG_VECTOR_LENGTH, '0);
    send_sample(16'sh5a5a);
    send_sample(16'sha5a5);
    settle();
  endtask

  task automatic test_mid_vector_change();
    // length lowered below the stored count, scale and bias changed too
    write_all(7'd8, 16'h0100, 16'h0000);
    send_vector(5);
    settle();
    write_all(7'd3, 16'h0180, 16'hff00);
    send_sample(pick_sample());
    settle();
    // length lowered to exactly the count after the next item
    write_reg(REG_VECTOR_LENGTH, 16'd8);
    send_vector(3);
    settle();
    write_reg(REG_VECTOR_LENGTH, 16'd4);
    send_sample(pick_sample());
    settle();
  endtask

  task automatic test_output_backpressure();
    write_all(7'd16, 16'h0100, 16'h0000);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    send_vector(48);
    settle();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  function automatic logic [LEN_W-1:0] pick_length(input int phase);
    if (phase == 0) return 7'h7f;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 7'd64;
      2: return LEN_W'($urandom_range(65, 127));
      3: return 7'd1;
      4, 5: return LEN_W'($urandom_range(13, 40));
      default: return LEN_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0100;
      3: return '0;
      4, 5: return DATA_W'($signed($urandom_range(0, 1023)) - 512);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic test_random_vectors();
    int phase;
    int n;
    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      settle();
      write_all(pick_length(phase), pick_coeff(), pick_coeff());
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = eff_length(len_reg);
      repeat ($urandom_range(1, 4)) begin
        if (sent_count < ITEM_TARGET) send_vector(n);
      end
      // leave a partial vector so the next settings land mid-vector
      if (n > 1 && sent_count < ITEM_TARGET && $urandom_range(0, 3) == 0)
        send_vector($urandom_range(1, n - 1));
      phase++;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_VECTOR_LENGTH;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_saturation_extremes();
    test_short_lengths();
    test_mid_vector_change();
    test_output_backpressure();
    test_random_vectors();

    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (normalized_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (normalized_q.size() != 0)
      note_error($sformatf("%0d items never arrived", normalized_q.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mcsb_pkg.sv
hdl/mcsb_if.sv
hdl/mcsb_ram.sv
hdl/mcsb_queue.sv
hdl/mcsb_front.sv
hdl/mcsb_back.sv
hdl/mean_center_scale_bias.sv
tb/sv/tb_top.sv
